// ===== rtl/fpa_pkg.sv =====
// Shared operation codes and stage-to-stage sideband type of the Q24.8 ALU.
`default_nettype none
package fpa_pkg;

	localparam int WORD_W = 32;
	localparam int OP_W   = 4;

	localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
	localparam logic [OP_W-1:0] OP_MIN     = 4'd4;
	localparam logic [OP_W-1:0] OP_MAX     = 4'd5;
	localparam logic [OP_W-1:0] OP_INC     = 4'd6;
	localparam logic [OP_W-1:0] OP_DEC     = 4'd7;
	localparam logic [OP_W-1:0] OP_TOINT   = 4'd8;
	localparam logic [OP_W-1:0] OP_FROMINT = 4'd9;

	// Everything about an item that rides along the divider row untouched.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] res;
		logic              less;
		logic              equal;
		logic              greater;
		logic              dz;
		logic              qneg;
	} side_t;

endpackage
`default_nettype wire

// ===== rtl/fpa_in_if.sv =====
// Input channel: operation and two operands with valid/ready.
`default_nettype none
interface fpa_in_if;
	logic              valid;
	logic              ready;
	logic [3:0]        operation;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source(output valid, operation, operand_a, operand_b, input ready);
	modport sink(input valid, operation, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpa_out_if.sv =====
// Output channel: result word and flags with valid/ready.
`default_nettype none
interface fpa_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic               less;
	logic               equal;
	logic               greater;
	logic               divide_by_zero;

	modport source(output valid, result, less, equal, greater, divide_by_zero,
		input ready);
	modport sink(input valid, result, less, equal, greater, divide_by_zero,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/fpa_front.sv =====
// Front stages: register operands and product, then form every non-divide result.
`default_nettype none
module fpa_front import fpa_pkg::*; #(
	parameter int FRAC_BITS = 8,
	parameter int DW        = 32 + FRAC_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [OP_W-1:0]   in_op,
	input  wire logic [WORD_W-1:0] in_a,
	input  wire logic [WORD_W-1:0] in_b,
	output logic                   valid_s2,
	output side_t                  side_s2,
	output logic [DW-1:0]          dq_s2,
	output logic [WORD_W-1:0]      dvs_s2
);

	logic                     valid_s1;
	logic [OP_W-1:0]          op_s1;
	logic signed [WORD_W-1:0] a_s1;
	logic signed [WORD_W-1:0] b_s1;
	logic signed [2*WORD_W-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= in_op;
			a_s1    <= in_a;
			b_s1    <= in_b;
			prod_s1 <= $signed(in_a) * $signed(in_b);
		end
	end

	logic              lt, eq, gt;
	logic [WORD_W-1:0] abs_a, abs_b, bias, toint_sum, res;

	always_comb begin
		lt    = a_s1 < b_s1;
		eq    = a_s1 == b_s1;
		gt    = a_s1 > b_s1;
		abs_a = a_s1[WORD_W-1] ? WORD_W'(-a_s1) : WORD_W'(a_s1);
		abs_b = b_s1[WORD_W-1] ? WORD_W'(-b_s1) : WORD_W'(b_s1);
		// round toward zero: bias negative values by one less than the scale
		bias      = {{(WORD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{a_s1[WORD_W-1]}}};
		toint_sum = a_s1 + bias;
		case (op_s1)
			OP_ADD:     res = a_s1 + b_s1;
			OP_SUB:     res = a_s1 - b_s1;
			OP_MUL:     res = prod_s1[FRAC_BITS +: WORD_W];
			OP_MIN:     res = lt ? a_s1 : b_s1;
			OP_MAX:     res = gt ? a_s1 : b_s1;
			OP_INC:     res = a_s1 + 1'b1;
			OP_DEC:     res = a_s1 - 1'b1;
			OP_TOINT:   res = WORD_W'($signed(toint_sum) >>> FRAC_BITS);
			OP_FROMINT: res = a_s1 << FRAC_BITS;
			default:    res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.op      <= op_s1;
			side_s2.res     <= res;
			side_s2.less    <= lt;
			side_s2.equal   <= eq;
			side_s2.greater <= gt;
			side_s2.dz      <= (op_s1 == OP_DIV) && (b_s1 == '0);
			side_s2.qneg    <= a_s1[WORD_W-1] ^ b_s1[WORD_W-1];
			dq_s2           <= {abs_a, {FRAC_BITS{1'b0}}};
			dvs_s2          <= abs_b;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fpa_div_cell.sv =====
// One restoring-division cell: settle one quotient bit and pass the item on.
`default_nettype none
module fpa_div_cell import fpa_pkg::*; #(
	parameter int DW = 40
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire side_t             in_side,
	input  wire logic [WORD_W-1:0] in_rem,
	input  wire logic [DW-1:0]     in_dq,
	input  wire logic [WORD_W-1:0] in_dvs,
	output logic                   valid_q,
	output side_t                  side_q,
	output logic [WORD_W-1:0]      rem_q,
	output logic [DW-1:0]          dq_q,
	output logic [WORD_W-1:0]      dvs_q
);

	logic [WORD_W:0] shifted, trial;
	logic            fits;

	always_comb begin
		// remainder stays below the divisor (at most 2^31), so the top bit is the borrow
		shifted = {in_rem, in_dq[DW-1]};
		trial   = shifted - {1'b0, in_dvs};
		fits    = !trial[WORD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			rem_q  <= fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
			dq_q   <= {in_dq[DW-2:0], fits};
			dvs_q  <= in_dvs;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fixed_point_q24_8_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
// Usage:
//   in_ch carries one transaction per item: operation, operand_a, operand_b.
//   out_ch returns one transaction per item: result and the less, equal,
//   greater and divide_by_zero flags, in the order the items were taken.
// Throughput: one item per cycle, every operation alike, unless the output stalls.
// Pipeline: two front stages (operand/product register, then
//   the non-divide result), one divider cell per dividend bit
//   (32 + FRAC_BITS cells), and the output register.
// Division is a row of restoring cells, each settling one quotient bit.
// Every operation travels the full row so results leave in order.
// Stall: the whole pipeline advances as one; when the output register is
//   full and out_ch.ready is low, every stage holds and in_ch.ready drops.
//   A waiting result does not block input while the output can drain.
// Reset: arst_n clears all valid bits at once; no results are pending
//   afterwards and the block accepts input in the first cycle.
`default_nettype none
module fixed_point_q24_8_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fpa_in_if.sink    in_ch,
	fpa_out_if.source out_ch
);

	localparam int DW = WORD_W + FRAC_BITS;

	logic en;

	// advance whenever the output register is empty or being drained
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	logic              valid_c [DW+1];
	side_t             side_c  [DW+1];
	logic [WORD_W-1:0] rem_c   [DW+1];
	logic [DW-1:0]     dq_c    [DW+1];
	logic [WORD_W-1:0] dvs_c   [DW+1];

	fpa_front #(
		.FRAC_BITS(FRAC_BITS),
		.DW       (DW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_ch.valid),
		.in_op   (in_ch.operation),
		.in_a    (in_ch.operand_a),
		.in_b    (in_ch.operand_b),
		.valid_s2(valid_c[0]),
		.side_s2 (side_c[0]),
		.dq_s2   (dq_c[0]),
		.dvs_s2  (dvs_c[0])
	);

	// division starts from a zero partial remainder
	assign rem_c[0] = '0;

	for (genvar i = 0; i < DW; i++) begin : g_cell
		fpa_div_cell #(.DW(DW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_valid(valid_c[i]),
			.in_side (side_c[i]),
			.in_rem  (rem_c[i]),
			.in_dq   (dq_c[i]),
			.in_dvs  (dvs_c[i]),
			.valid_q (valid_c[i+1]),
			.side_q  (side_c[i+1]),
			.rem_q   (rem_c[i+1]),
			.dq_q    (dq_c[i+1]),
			.dvs_q   (dvs_c[i+1])
		);
	end

	side_t             side_end;
	logic [WORD_W-1:0] quot, final_res;

	always_comb begin
		side_end = side_c[DW];
		// keep the low word of the quotient and restore its sign
		quot = dq_c[DW][WORD_W-1:0];
		if (side_end.op == OP_DIV) begin
			if (side_end.dz) begin
				final_res = '0;
			end else begin
				final_res = side_end.qneg ? WORD_W'(-quot) : quot;
			end
		end else begin
			final_res = side_end.res;
		end
	end

	logic              out_valid_q;
	logic [WORD_W-1:0] result_q;
	logic              less_q, equal_q, greater_q, dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q  <= final_res;
			less_q    <= side_end.less;
			equal_q   <= side_end.equal;
			greater_q <= side_end.greater;
			dz_q      <= side_end.dz;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result         = result_q;
	assign out_ch.less           = less_q;
	assign out_ch.equal          = equal_q;
	assign out_ch.greater        = greater_q;
	assign out_ch.divide_by_zero = dz_q;

endmodule
`default_nettype wire

// ===== tb/fixed_point_q24_8_alu_test.sv =====
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
module fixed_point_q24_8_alu_test import fpa_pkg::*;;

	localparam int FRAC = 8;
	localparam int LATENCY = FRAC + 35;
	localparam int RANDOM_ITEMS = 1700;

	// One result transaction as the output channel carries it.
	typedef struct {
		logic signed [31:0] result;
		logic               less;
		logic               equal;
		logic               greater;
		logic               dz;
	} alu_result_t;

	// One row of the directed table; has_result marks rows typed in by hand.
	typedef struct {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit                 has_result;
		logic signed [31:0] result;
		logic               dz;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpa_in_if  in_ch();
	fpa_out_if out_ch();

	fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	alu_result_t pending_results[$];
	int mismatches = 0;
	bit stimulus_done = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.operation = OP_ADD;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		out_ch.ready = 1'b0;
	end

	// Compute the ALU result for one operation; compare flags come for every code.
	function automatic alu_result_t alu_predict(logic [3:0] op, logic signed [31:0] a,
			logic signed [31:0] b);
		alu_result_t r;
		logic signed [63:0] wide;
		logic signed [63:0] num;
		r.less = a < b;
		r.equal = a == b;
		r.greater = a > b;
		r.dz = 1'b0;
		r.result = '0;
		case (op)
			OP_ADD: r.result = a + b;
			OP_SUB: r.result = a - b;
			OP_MUL: begin
				wide = 64'(a) * 64'(b);
				r.result = wide[FRAC+31:FRAC];
			end
			OP_DIV: begin
				if (b == 0) begin
					r.dz = 1'b1;
				end else begin
					num = 64'(a) <<< FRAC;
					wide = num / 64'(b);
					r.result = wide[31:0];
				end
			end
			OP_MIN: r.result = (a < b) ? a : b;
			OP_MAX: r.result = (a > b) ? a : b;
			OP_INC: r.result = a + 32'sd1;
			OP_DEC: r.result = a - 32'sd1;
			OP_TOINT: r.result = a / (32'sd1 <<< FRAC);
			OP_FROMINT: r.result = a <<< FRAC;
			default: r.result = '0;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Drive one transaction and hold it until the block takes it.
	task automatic send_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b,
			alu_result_t expected);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// drop valid only while idling, so back-to-back items keep it high
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_results.push_back(expected);
	endtask

	// Random operand, weighted toward edges and small fixed-point magnitudes.
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'($urandom_range(0, 4)) - 32'sd2;
			3, 4: return 32'($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
			default: return $urandom;
		endcase
	endfunction

	// Sink side: random stalls, with long stretches of steady ready.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	// Check every accepted result transaction against the oldest expectation.
	always @(posedge clk) begin
		alu_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", out_ch.result, '0);
			end else begin
				want = pending_results.pop_front();
				if (out_ch.result !== want.result)
					report_mismatch("result", out_ch.result, want.result);
				if (out_ch.less !== want.less)
					report_mismatch("less", 32'(out_ch.less), 32'(want.less));
				if (out_ch.equal !== want.equal)
					report_mismatch("equal", 32'(out_ch.equal), 32'(want.equal));
				if (out_ch.greater !== want.greater)
					report_mismatch("greater", 32'(out_ch.greater), 32'(want.greater));
				if (out_ch.divide_by_zero !== want.dz)
					report_mismatch("divide_by_zero", 32'(out_ch.divide_by_zero),
						32'(want.dz));
			end
		end
	end

	initial begin
		directed_row_t table_rows[$];
		alu_result_t want;
		logic [3:0] op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		// Directed rows: extremes, every code, zero divisor and unused codes.
		table_rows = '{
			'{OP_ADD, 32'sh7FFF_FFFF, 32'sd1, 1'b1, 32'sh8000_0000, 1'b0},
			'{OP_SUB, 32'sh8000_0000, 32'sd1, 1'b1, 32'sh7FFF_FFFF, 1'b0},
			'{OP_MUL, 32'sd512, 32'sd768, 1'b1, 32'sd1536, 1'b0},
			'{OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0, 1'b0},
			'{OP_MUL, -32'sd1, 32'sd1, 1'b1, -32'sd1, 1'b0},
			'{OP_DIV, 32'sd768, 32'sd512, 1'b1, 32'sd384, 1'b0},
			'{OP_DIV, 32'sd5, 32'sd0, 1'b1, 32'sd0, 1'b1},
			'{OP_DIV, 32'sh8000_0000, -32'sd1, 1'b0, '0, 1'b0},
			'{OP_DIV, -32'sd7, 32'sd2048, 1'b0, '0, 1'b0},
			'{OP_MIN, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh8000_0000, 1'b0},
			'{OP_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b0},
			'{OP_MAX, 32'sd3, 32'sd3, 1'b1, 32'sd3, 1'b0},
			'{OP_INC, 32'sh7FFF_FFFF, 32'sd0, 1'b1, 32'sh8000_0000, 1'b0},
			'{OP_DEC, 32'sh8000_0000, 32'sd0, 1'b1, 32'sh7FFF_FFFF, 1'b0},
			'{OP_TOINT, -32'sd257, 32'sd0, 1'b1, -32'sd1, 1'b0},
			'{OP_TOINT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 32'sh007F_FFFF, 1'b0},
			'{OP_FROMINT, 32'sh00FF_FFFF, -32'sd1, 1'b1, 32'shFFFF_FF00, 1'b0},
			'{OP_FROMINT, 32'sh8000_0000, 32'sd0, 1'b1, 32'sd0, 1'b0},
			'{4'd10, 32'sd1, 32'sd2, 1'b1, 32'sd0, 1'b0},
			'{4'd15, -32'sd1, 32'sh8000_0000, 1'b1, 32'sd0, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i]) begin
			want = alu_predict(table_rows[i].op, table_rows[i].a, table_rows[i].b);
			// Typed-in rows take the hand-written result and flag over the predictor.
			if (table_rows[i].has_result) begin
				want.result = table_rows[i].result;
				want.dz = table_rows[i].dz;
			end
			send_item(table_rows[i].op, table_rows[i].a, table_rows[i].b, want);
		end
		in_ch.valid <= 1'b0;

		// Hold off until the pipeline has drained completely once.
		while (pending_results.size() != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			a = pick_operand();
			b = ($urandom_range(0, 15) == 0) ? 32'sd0 : pick_operand();
			if ($urandom_range(0, 15) == 0) b = a;
			send_item(op, a, b, alu_predict(op, a, b));
		end
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Limit: far beyond the slowest run (about 1720 items).
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
